@@ rtl/phcp_pkg.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Host bridge configuration space package
// Shared types, codes and default-value tables for the configuration block.
// ----------------------------------------------------------------------------
package phcp_pkg;

    localparam int KIND_W = 2;
    localparam int FUNC_W = 3;
    localparam int OFF_W  = 8;
    localparam int DATA_W = 8;
    localparam int BASE_W = 20;
    localparam int SIZE_W = 17;
    localparam int DEPTH  = 256;

    localparam logic [KIND_W-1:0] KIND_READ   = 2'd0;
    localparam logic [KIND_W-1:0] KIND_WRITE  = 2'd1;
    localparam logic [KIND_W-1:0] KIND_MRESET = 2'd2;
    localparam logic [KIND_W-1:0] KIND_RELOAD = 2'd3;

    localparam logic RES_READ   = 1'b0;
    localparam logic RES_REGION = 1'b1;

    localparam logic [OFF_W-1:0] PAM0_OFF = 8'h59;
    localparam logic [OFF_W-1:0] PAM1_OFF = 8'h5A;
    localparam logic [OFF_W-1:0] PAM6_OFF = 8'h5F;

    localparam logic [BASE_W-1:0] PAM0_BASE = 20'hF0000;
    localparam logic [BASE_W-1:0] PAM_BASE  = 20'hC0000;
    localparam logic [BASE_W-1:0] HALF_STEP = 20'h04000;
    localparam logic [SIZE_W-1:0] PAM0_SIZE = 17'h10000;
    localparam logic [SIZE_W-1:0] PAM_SIZE  = 17'h04000;
    localparam logic [DATA_W-1:0] BYTE_ONES = 8'hFF;

    typedef struct packed {
        logic [KIND_W-1:0] kind;
        logic [FUNC_W-1:0] function_number;
        logic [OFF_W-1:0]  reg_offset;
        logic [DATA_W-1:0] write_data;
    } t_req;

    typedef struct packed {
        logic              result_kind;
        logic [DATA_W-1:0] read_data;
        logic [BASE_W-1:0] region_base;
        logic [SIZE_W-1:0] region_size;
        logic              read_internal;
        logic              write_internal;
        logic              shadow_bios;
        logic              last;
    } t_res;

    typedef struct packed {
        logic load;
        logic exec;
    } t_cmd;

    typedef struct packed {
        logic res_empty;
    } t_sts;

    function automatic logic [DATA_W-1:0] phcp_default(input logic alt,
                                                       input logic [OFF_W-1:0] off);
        logic [DATA_W-1:0] v;
        begin
            v = '0;
            case (off)
                8'h00: v = 8'h86;
                8'h01: v = 8'h80;
                8'h02: v = 8'h22;
                8'h03: v = 8'h01;
                8'h04: v = 8'h06;
                8'h07: v = alt ? 8'h02 : 8'h82;
                8'h0B: v = 8'h06;
                8'h52: v = alt ? 8'h42 : 8'h40;
                8'h53: v = alt ? 8'h14 : 8'h00;
                8'h56: v = alt ? 8'h52 : 8'h00;
                8'h57: v = 8'h01;
                8'h60: v = 8'h02;
                8'h61: v = 8'h02;
                8'h62: v = 8'h02;
                8'h63: v = 8'h02;
                8'h64: v = 8'h02;
                8'h67: v = alt ? 8'h11 : 8'h00;
                8'h69: v = alt ? 8'h03 : 8'h00;
                8'h70: v = alt ? 8'h20 : 8'h00;
                8'h72: v = 8'h02;
                8'h74: v = alt ? 8'h0E : 8'h00;
                8'h78: v = alt ? 8'h23 : 8'h00;
                default: v = '0;
            endcase
            return v;
        end
    endfunction

    function automatic logic phcp_read_only(input logic [OFF_W-1:0] off);
        logic ro;
        begin
            ro = (off >= 8'h10) && (off < 8'h4F);
            case (off)
                8'h00, 8'h01, 8'h02, 8'h03, 8'h08, 8'h09,
                8'h0A, 8'h0B, 8'h0C, 8'h0E: ro = 1'b1;
                default: ro = ro;
            endcase
            return ro;
        end
    endfunction

    function automatic logic [DATA_W-1:0] phcp_mask(input logic [OFF_W-1:0] off,
                                                    input logic [DATA_W-1:0] val);
        logic [DATA_W-1:0] v;
        begin
            case (off)
                8'h04: v = (val & 8'h02) | 8'h04;
                8'h05: v = 8'h00;
                8'h06: v = 8'h00;
                8'h07: v = 8'h02;
                default: v = val;
            endcase
            return v;
        end
    endfunction

endpackage

@@ rtl/phcp_req_if.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Request channel
// Carries one configuration access request with a valid/ready handshake.
// ----------------------------------------------------------------------------
interface phcp_req_if
    import phcp_pkg::*;
();
    logic              valid;
    logic              ready;
    logic [KIND_W-1:0] kind;
    logic [FUNC_W-1:0] function_number;
    logic [OFF_W-1:0]  reg_offset;
    logic [DATA_W-1:0] write_data;

    modport source (output valid, kind, function_number, reg_offset, write_data,
                    input ready);
    modport sink   (input valid, kind, function_number, reg_offset, write_data,
                    output ready);
endinterface

@@ rtl/phcp_res_if.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Result channel
// Carries read data and region attribute events with a valid/ready handshake.
// ----------------------------------------------------------------------------
interface phcp_res_if
    import phcp_pkg::*;
();
    logic              valid;
    logic              ready;
    logic              result_kind;
    logic [DATA_W-1:0] read_data;
    logic [BASE_W-1:0] region_base;
    logic [SIZE_W-1:0] region_size;
    logic              read_internal;
    logic              write_internal;
    logic              shadow_bios;
    logic              last;

    modport source (output valid, result_kind, read_data, region_base, region_size,
                    read_internal, write_internal, shadow_bios, last,
                    input ready);
    modport sink   (input valid, result_kind, read_data, region_base, region_size,
                    read_internal, write_internal, shadow_bios, last,
                    output ready);
endinterface

@@ rtl/phcp_cfg_if.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Configuration write channel
// Writes the board variant register with a valid/ready handshake.
// ----------------------------------------------------------------------------
interface phcp_cfg_if;
    logic valid;
    logic ready;
    logic board_variant;

    modport source (output valid, board_variant, input ready);
    modport sink   (input valid, board_variant, output ready);
endinterface

@@ rtl/phcp_ctrl.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Configuration block controller
// Two-state sequencer: accept a request, then execute it once the result
// buffer is free.
// ----------------------------------------------------------------------------
module phcp_ctrl
    import phcp_pkg::*;
(
    input  logic i_clk,
    input  logic i_rst_n,
    input  logic i_req_valid,
    output logic o_req_ready,
    input  t_sts i_sts,
    output t_cmd o_cmd
);

    localparam logic ST_IDLE = 1'b0;
    localparam logic ST_EXEC = 1'b1;

    logic r_state;
    logic n_state;

    always_comb begin
        n_state     = r_state;
        o_req_ready = 1'b0;
        o_cmd       = '0;
        case (r_state)
            ST_IDLE: begin
                o_req_ready = 1'b1;
                if (i_req_valid) begin
                    o_cmd.load = 1'b1;
                    n_state    = ST_EXEC;
                end
            end
            ST_EXEC: begin
                if (i_sts.res_empty) begin
                    o_cmd.exec = 1'b1;
                    n_state    = ST_IDLE;
                end
            end
            default: n_state = ST_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

endmodule

@@ rtl/phcp_dp.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Configuration block datapath
// Byte store with per-entry valid bits, write rules, PAM event generation
// and a two-entry result buffer.
// ----------------------------------------------------------------------------
module phcp_dp
    import phcp_pkg::*;
(
    input  logic i_clk,
    input  logic i_rst_n,
    input  t_cmd i_cmd,
    output t_sts o_sts,
    input  t_req i_req,
    input  logic i_cfg_valid,
    input  logic i_cfg_data,
    output logic o_res_valid,
    input  logic i_res_ready,
    output t_res o_res
);

    logic [DATA_W-1:0] r_mem [DEPTH];
    logic [DEPTH-1:0]  r_vld;
    logic [DATA_W-1:0] r_rdata;
    logic              r_hit;
    logic [OFF_W-1:0]  r_addr;
    t_req              r_req;
    logic              r_bvar;
    logic              r_dvar;
    logic              r_shadow;
    t_res              r_slot0;
    t_res              r_slot1;
    logic [1:0]        r_cnt;

    logic [OFF_W-1:0]  n_addr;
    logic [DATA_W-1:0] stored;
    logic [DATA_W-1:0] wval;
    logic [DATA_W-1:0] diff;
    logic              is_rd;
    logic              is_rl;
    logic              is_wr;
    logic              do_store;
    logic              is_pam0;
    logic              is_pam16;
    logic              ev_lo;
    logic              ev_hi;
    logic              n_shadow;
    logic [2:0]        pam_idx;
    logic [BASE_W-1:0] lo_base;
    t_res              res_rd;
    t_res              res_lo;
    t_res              res_hi;
    t_res              n_slot0;
    t_res              n_slot1;
    logic [1:0]        n_cnt;

    assign n_addr = (i_req.kind == KIND_MRESET) ? PAM0_OFF : i_req.reg_offset;

    always_ff @(posedge i_clk) begin
        if (i_cmd.load) begin
            r_rdata <= r_mem[n_addr];
            r_hit   <= r_vld[n_addr];
            r_addr  <= n_addr;
            r_req   <= i_req;
        end
        if (do_store) begin
            r_mem[r_addr] <= wval;
        end
    end

    always_comb begin
        stored   = r_hit ? r_rdata : phcp_default(r_dvar, r_addr);
        is_rd    = (r_req.kind == KIND_READ);
        is_rl    = (r_req.kind == KIND_RELOAD);
        is_wr    = ((r_req.kind == KIND_WRITE) && (r_req.function_number == '0))
                   || (r_req.kind == KIND_MRESET);
        wval     = phcp_mask(r_addr, (r_req.kind == KIND_MRESET) ? '0 : r_req.write_data);
        do_store = i_cmd.exec && is_wr && !phcp_read_only(r_addr);
        diff     = stored ^ wval;
        is_pam0  = (r_addr == PAM0_OFF);
        is_pam16 = (r_addr >= PAM1_OFF) && (r_addr <= PAM6_OFF);
        ev_lo    = is_pam16 && (diff[3:0] != '0);
        ev_hi    = (is_pam0 || is_pam16) && (diff[7:4] != '0);
        n_shadow = (is_wr && is_pam0 && ev_hi) ? wval[4] : r_shadow;
        pam_idx  = 3'(r_addr - PAM1_OFF);
        lo_base  = PAM_BASE + {2'b00, pam_idx, 15'd0};

        res_rd                = '0;
        res_rd.result_kind    = RES_READ;
        res_rd.read_data      = (r_req.function_number != '0) ? BYTE_ONES : stored;
        res_rd.shadow_bios    = r_shadow;
        res_rd.last           = 1'b1;

        res_lo                = '0;
        res_lo.result_kind    = RES_REGION;
        res_lo.region_base    = lo_base;
        res_lo.region_size    = PAM_SIZE;
        res_lo.read_internal  = wval[0];
        res_lo.write_internal = wval[1];
        res_lo.shadow_bios    = n_shadow;
        res_lo.last           = !ev_hi;

        res_hi                = '0;
        res_hi.result_kind    = RES_REGION;
        res_hi.region_base    = is_pam0 ? PAM0_BASE : (lo_base + HALF_STEP);
        res_hi.region_size    = is_pam0 ? PAM0_SIZE : PAM_SIZE;
        res_hi.read_internal  = wval[4];
        res_hi.write_internal = wval[5];
        res_hi.shadow_bios    = n_shadow;
        res_hi.last           = 1'b1;

        n_slot0 = r_slot0;
        n_slot1 = r_slot1;
        n_cnt   = r_cnt;
        if (i_cmd.exec) begin
            if (is_rd) begin
                n_slot0 = res_rd;
                n_cnt   = 2'd1;
            end else if (do_store) begin
                n_slot0 = ev_lo ? res_lo : res_hi;
                n_slot1 = res_hi;
                n_cnt   = {1'b0, ev_lo} + {1'b0, ev_hi};
            end
        end else if (o_res_valid && i_res_ready) begin
            n_slot0 = r_slot1;
            n_cnt   = r_cnt - 2'd1;
        end
    end

    always_ff @(posedge i_clk) begin
        r_slot0 <= n_slot0;
        r_slot1 <= n_slot1;
        if (!i_rst_n) begin
            r_vld    <= '0;
            r_bvar   <= 1'b0;
            r_dvar   <= 1'b0;
            r_shadow <= 1'b0;
            r_cnt    <= '0;
        end else begin
            r_cnt <= n_cnt;
            if (i_cfg_valid) begin
                r_bvar <= i_cfg_data;
            end
            if (i_cmd.exec && is_rl) begin
                r_vld  <= '0;
                r_dvar <= r_bvar;
            end else if (do_store) begin
                r_vld[r_addr] <= 1'b1;
            end
            if (do_store) begin
                r_shadow <= n_shadow;
            end
        end
    end

    assign o_sts.res_empty = (r_cnt == '0);
    assign o_res_valid     = (r_cnt != '0);
    assign o_res           = r_slot0;

endmodule

@@ rtl/pci_host_bridge_config_pam_core.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Host bridge configuration space with programmable attribute map
// Function-zero configuration byte store with write rules and PAM events.
// ----------------------------------------------------------------------------
// Requests arrive on i_req: read, write, PCI master reset or defaults reload.
// Results leave on o_res: one read result per read request, and zero to two
// region events per write or master reset, the final one marked by last.
// i_cfg writes the board variant used by the next defaults reload; it is
// always ready and should be written only while the block is idle.
// Each request takes two steps: reading the byte store, then applying the
// write rules and loading the two-entry result buffer. A new request is
// accepted while results are still waiting; its second step waits until
// the buffer has drained, so a stalled receiver holds up the next request.
// A defaults reload takes effect by clearing the per-byte valid bits.
// Reset restores the variant-zero defaults, clears the shadow flag and
// empties the result buffer; no clearing pass is needed.
// ----------------------------------------------------------------------------
module pci_host_bridge_config_pam_core
    import phcp_pkg::*;
(
    input  logic        i_clk,
    input  logic        i_rst_n,
    phcp_req_if.sink    i_req,
    phcp_res_if.source  o_res,
    phcp_cfg_if.sink    i_cfg
);

    t_cmd cmd;
    t_sts sts;
    t_req req;
    t_res res;
    logic req_ready;
    logic res_valid;

    assign req.kind            = i_req.kind;
    assign req.function_number = i_req.function_number;
    assign req.reg_offset      = i_req.reg_offset;
    assign req.write_data      = i_req.write_data;
    assign i_req.ready         = req_ready;
    assign i_cfg.ready         = 1'b1;

    phcp_ctrl u_ctrl (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_req_valid (i_req.valid),
        .o_req_ready (req_ready),
        .i_sts       (sts),
        .o_cmd       (cmd)
    );

    phcp_dp u_dp (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cmd       (cmd),
        .o_sts       (sts),
        .i_req       (req),
        .i_cfg_valid (i_cfg.valid),
        .i_cfg_data  (i_cfg.board_variant),
        .o_res_valid (res_valid),
        .i_res_ready (o_res.ready),
        .o_res       (res)
    );

    assign o_res.valid          = res_valid;
    assign o_res.result_kind    = res.result_kind;
    assign o_res.read_data      = res.read_data;
    assign o_res.region_base    = res.region_base;
    assign o_res.region_size    = res.region_size;
    assign o_res.read_internal  = res.read_internal;
    assign o_res.write_internal = res.write_internal;
    assign o_res.shadow_bios    = res.shadow_bios;
    assign o_res.last           = res.last;

endmodule
